@@ hdl/cubic_fractional_resampler_top_macros.svh @@
// Assertion macros for the resampler top level.
`ifndef CUBIC_FRACTIONAL_RESAMPLER_TOP_MACROS_SVH
`define CUBIC_FRACTIONAL_RESAMPLER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cfr_pkg.sv @@
// Package: widths, constants, types and state codes of the cubic resampler.
package cfr_pkg;

    // Sample and phase formats
    localparam int SAMPLE_BITS      = 16;
    localparam int PHASE_FRAC_BITS  = 16;
    localparam int PHASE_BITS       = PHASE_FRAC_BITS + 5;
    localparam int MAX_OUTPUTS      = 64;
    localparam int CNT_BITS         = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

    // Configuration register widths
    localparam int RATE_BITS        = 21;
    localparam int INIT_BITS        = 16;
    localparam int CFG_DATA_BITS    = 21;
    localparam int CFG_IDX_BITS     = 1;

    // Horner accumulator: coefficients and partial results stay within 13 * 2^(S-1)
    localparam int T_BITS           = SAMPLE_BITS + 5;
    localparam int PROD_BITS        = T_BITS + PHASE_FRAC_BITS + 1;
    localparam int SUM_BITS         = ((PHASE_BITS > RATE_BITS) ? PHASE_BITS : RATE_BITS) + 1;

    localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << PHASE_FRAC_BITS;
    localparam logic [PHASE_BITS-1:0] PHASE_MAX = '1;
    localparam logic [RATE_BITS-1:0]  RATE_RESET = RATE_BITS'(65536);
    localparam logic [INIT_BITS-1:0]  INIT_RESET = '0;

    // Rounding offset: one half in the product's fraction
    localparam logic signed [PROD_BITS-1:0] RND_HALF =
        {{(PROD_BITS-PHASE_FRAC_BITS){1'b0}}, 1'b1, {(PHASE_FRAC_BITS-1){1'b0}}};

    // Window fill
    localparam logic [2:0] FILL_FULL = 3'd4;

    // Horner step of the last coefficient
    localparam logic [1:0] HORNER_LAST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE_STEP     = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_PHASE = 1'b1;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_LOAD  = 6'b000100,
        S_MUL   = 6'b001000,
        S_ACC   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // Commands from the sequencer to the shared Horner unit
    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
    } t_hrn_ctrl;

endpackage

@@ hdl/cfr_horner.sv @@
// Shared multiply, round and add unit that evaluates the cubic in Horner form.
module cfr_horner
    import cfr_pkg::*;
(
    input  logic                        i_clk,
    input  t_hrn_ctrl                   i_ctrl,
    input  logic signed [T_BITS-1:0]    i_coef,
    input  logic [PHASE_FRAC_BITS-1:0]  i_mu,
    output logic signed [T_BITS-1:0]    o_t
);

    logic signed [T_BITS-1:0]    r_t;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [PROD_BITS-1:0] w_prod_rnd;
    logic signed [PROD_BITS-1:0] w_prod_shift;
    logic signed [T_BITS-1:0]    w_acc;

    // Round half up, then floor by the phase fraction
    assign w_prod_rnd   = r_prod + RND_HALF;
    assign w_prod_shift = w_prod_rnd >>> PHASE_FRAC_BITS;
    assign w_acc        = w_prod_shift[T_BITS-1:0] + i_coef;

    // Product register, then accumulator register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= r_t * $signed({1'b0, i_mu});
        end
        if (i_ctrl.load) begin
            r_t <= i_coef;
        end else if (i_ctrl.acc) begin
            r_t <= w_acc;
        end
    end

    assign o_t = r_t;

endmodule

@@ hdl/cubic_fractional_resampler_top.sv @@
// Top level: sample window, phase accumulator, sequencer and output register.
//
//  channel   direction  payload (low bit first)               transaction
//  s_axis    in         tdata: sample_real[15:0], imag[31:16]  tvalid & tready
//  m_axis    out        tdata: out_real[15:0], out_imag[31:16] tvalid & tready
//                       tlast: last_of_run
//  cfg       in         i_cfg_index, i_cfg_wdata[20:0]         i_cfg_we
//
// An input is taken while idle; once the window is full, a check state follows.
// Each output runs, per component, a load plus three multiply/add pairs through
// one shared multiplier, then a hand-off to the output register.
// An input gives up to 64 outputs.
// Reset is synchronous, active low, and has no clearing pass.
// The output register lets the next input in while the last result waits;
// a stalled output holds the sequencer in its hand-off cycle.
module cubic_fractional_resampler_top
    import cfr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input stream, tdata: sample_real, sample_imag
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [2*SAMPLE_BITS-1:0]  s_axis_tdata,
    // Output stream, tdata: out_real, out_imag
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [2*SAMPLE_BITS-1:0]  m_axis_tdata,
    output logic                      m_axis_tlast,
    // Configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata
);

    `include "cubic_fractional_resampler_top_macros.svh"

    // Control state
    t_state                    r_state, n_state;
    logic [2:0]                r_fill, n_fill;
    logic [PHASE_BITS-1:0]     r_phase, n_phase;
    logic [CNT_BITS-1:0]       r_count, n_count;
    logic [1:0]                r_step, n_step;
    logic                      r_comp, n_comp;
    logic                      r_out_valid, n_out_valid;
    logic [RATE_BITS-1:0]      r_rate;
    logic [INIT_BITS-1:0]      r_init;

    // Payload
    logic signed [SAMPLE_BITS-1:0] r_win_re [4];
    logic signed [SAMPLE_BITS-1:0] r_win_im [4];
    logic signed [SAMPLE_BITS-1:0] r_res_re, n_res_re;
    logic signed [SAMPLE_BITS-1:0] r_out_re, n_out_re;
    logic signed [SAMPLE_BITS-1:0] r_out_im, n_out_im;
    logic                          r_out_last, n_out_last;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic                          w_last;
    logic [SUM_BITS-1:0]           w_sum;
    logic [PHASE_BITS-1:0]         w_phase_adv;
    logic signed [T_BITS-1:0]      w_y0, w_y1, w_y2, w_y3;
    logic signed [T_BITS-1:0]      w_a0, w_a1, w_a2;
    logic signed [T_BITS-1:0]      w_coef;
    logic signed [T_BITS-1:0]      w_t;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    t_hrn_ctrl                     w_ctrl;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Component select and cubic coefficients
    always_comb begin
        if (r_comp) begin
            w_y0 = T_BITS'(r_win_im[0]);
            w_y1 = T_BITS'(r_win_im[1]);
            w_y2 = T_BITS'(r_win_im[2]);
            w_y3 = T_BITS'(r_win_im[3]);
        end else begin
            w_y0 = T_BITS'(r_win_re[0]);
            w_y1 = T_BITS'(r_win_re[1]);
            w_y2 = T_BITS'(r_win_re[2]);
            w_y3 = T_BITS'(r_win_re[3]);
        end
    end

    assign w_a0 = w_y3 - w_y2 - w_y0 + w_y1;
    assign w_a1 = w_y0 - w_y1 - w_a0;
    assign w_a2 = w_y2 - w_y0;

    // Coefficient for the current Horner step
    always_comb begin
        if (r_state == S_LOAD) begin
            w_coef = w_a0;
        end else if (r_step == 2'd0) begin
            w_coef = w_a1;
        end else if (r_step == 2'd1) begin
            w_coef = w_a2;
        end else begin
            w_coef = w_y1;
        end
    end

    assign w_ctrl.load = (r_state == S_LOAD);
    assign w_ctrl.mul  = (r_state == S_MUL);
    assign w_ctrl.acc  = (r_state == S_ACC);

    cfr_horner u_horner (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_coef (w_coef),
        .i_mu   (r_phase[PHASE_FRAC_BITS-1:0]),
        .o_t    (w_t)
    );

    // Saturate the Horner result to the sample width
    always_comb begin
        if (&w_t[T_BITS-1:SAMPLE_BITS-1] || ~|w_t[T_BITS-1:SAMPLE_BITS-1]) begin
            w_sat = w_t[SAMPLE_BITS-1:0];
        end else if (w_t[T_BITS-1]) begin
            w_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Phase advance with saturation, and end-of-run detection
    assign w_sum       = SUM_BITS'(r_phase) + SUM_BITS'(r_rate);
    assign w_phase_adv = (w_sum > SUM_BITS'(PHASE_MAX)) ? PHASE_MAX : w_sum[PHASE_BITS-1:0];
    assign w_last      = (r_count == CNT_BITS'(MAX_OUTPUTS - 1)) || (w_phase_adv >= PHASE_ONE);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_phase     = r_phase;
        n_count     = r_count;
        n_step      = r_step;
        n_comp      = r_comp;
        n_res_re    = r_res_re;
        n_out_re    = r_out_re;
        n_out_im    = r_out_im;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !m_axis_tready;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_fill != FILL_FULL) begin
                        n_fill = r_fill + 3'd1;
                        if (r_fill == FILL_FULL - 3'd1) begin
                            n_phase = PHASE_BITS'(r_init);
                            n_state = S_CHECK;
                        end
                    end else begin
                        n_phase = (r_phase >= PHASE_ONE) ? r_phase - PHASE_ONE : '0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_count = '0;
                n_comp  = 1'b0;
                n_state = (r_phase < PHASE_ONE) ? S_LOAD : S_IDLE;
            end
            S_LOAD: begin
                // Real part finished when the imaginary pass starts
                if (r_comp) begin
                    n_res_re = w_sat;
                end
                n_step  = 2'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_step == HORNER_LAST) begin
                    if (r_comp) begin
                        n_state = S_OUT;
                    end else begin
                        n_comp  = 1'b1;
                        n_state = S_LOAD;
                    end
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_re    = r_res_re;
                    n_out_im    = w_sat;
                    n_out_last  = w_last;
                    n_phase     = w_phase_adv;
                    n_count     = r_count + CNT_BITS'(1);
                    n_comp      = 1'b0;
                    n_state     = w_last ? S_IDLE : S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_phase     <= PHASE_BITS'(INIT_RESET);
            r_count     <= '0;
            r_step      <= '0;
            r_comp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_step      <= n_step;
            r_comp      <= n_comp;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_init <= INIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_RATE_STEP) begin
                r_rate <= i_cfg_wdata[RATE_BITS-1:0];
            end
            if (i_cfg_index == REG_INITIAL_PHASE) begin
                r_init <= i_cfg_wdata[INIT_BITS-1:0];
            end
        end
    end

    // Sample window (y0 oldest) and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_win_re[0] <= r_win_re[1];
            r_win_re[1] <= r_win_re[2];
            r_win_re[2] <= r_win_re[3];
            r_win_re[3] <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_win_im[0] <= r_win_im[1];
            r_win_im[1] <= r_win_im[2];
            r_win_im[2] <= r_win_im[3];
            r_win_im[3] <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        r_res_re   <= n_res_re;
        r_out_re   <= n_out_re;
        r_out_im   <= n_out_im;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_im, r_out_re};
    assign m_axis_tlast  = r_out_last;

    // Checks
    `CFR_ASSERT_IMPL(a_check_full, r_state == S_CHECK, r_fill == FILL_FULL, "check without full window")
    `CFR_ASSERT_IMPL(a_mu_below_one, r_state == S_MUL, r_phase < PHASE_ONE, "multiply with phase at or above one")
    `CFR_ASSERT_NEXT(a_stall_holds_count, r_state == S_OUT && r_out_valid && !m_axis_tready, $stable(r_count) && $stable(r_phase), "sequencer advanced on a stalled output")
    `CFR_ASSERT_NEXT(a_last_ends_run, r_state == S_OUT && w_out_free && w_last, r_state == S_IDLE && m_axis_tlast, "run did not end on last output")

endmodule
